>>> hdl/tick_priority_task_scheduler_assert.svh
// Assertion macros for the checker file.
`ifndef TICK_PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define TICK_PRIORITY_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TPTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpts assertion failed");

// Next-cycle implication, disabled during reset.
`define TPTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpts assertion failed");

`endif

>>> hdl/tpts_pkg.sv
package tpts_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [31:0] SLEEP_TICK     = 32'hFFFF_FFFF;
	localparam logic [31:0] MAX_DELAY_TICK = 32'hFFFF_FFFE;

	localparam logic [2:0] OPC_TICK   = 3'd0;
	localparam logic [2:0] OPC_CREATE = 3'd1;
	localparam logic [2:0] OPC_YIELD  = 3'd2;
	localparam logic [2:0] OPC_SLEEP  = 3'd3;
	localparam logic [2:0] OPC_WAKE   = 3'd4;
	localparam logic [2:0] OPC_START  = 3'd5;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_CREATE,
		OP_YIELD,
		OP_SLEEP,
		OP_WAKE,
		OP_START
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  slot;
		logic [7:0]  pri;
		logic [31:0] delay;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN
	} state_t;

endpackage

>>> hdl/tick_priority_task_scheduler.sv
// Task scheduler: one operation per start beat, one result per operation.
// Input: an operation beat is taken at a clock edge with start high and busy low.
// Fields opcode, slot, priority_req and delay come with it.
// Output: done pulses for one cycle with next_task and switch_request valid;
// the receiver cannot stall, so each result must be taken in that cycle.
// A front stage decodes the beat into a command and pushes it into a
// two-entry queue; the back end pops it, updates the task table and, for
// scheduling operations, scans all MAX_TASKS slots one per cycle through a
// registered read port.
// Back-end steps per operation: pop, execute and, when scheduling runs, a scan
// of every slot and a drain step; done is registered after the last step.
// busy rises while the front stage holds a beat and the queue is full.
// Reset clears the used flags, tick count, stamp counter, current and chosen
// task and the started flag; the table contents stay undefined until created.
module tick_priority_task_scheduler #(
	parameter int MAX_TASKS = tpts_pkg::MAX_TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [3:0]  slot,
	input  logic [7:0]  priority_req,
	input  logic [31:0] delay,
	output logic        done,
	output logic [3:0]  next_task,
	output logic        switch_request
);

	logic           push;
	logic           full;
	logic           pop;
	logic           empty;
	tpts_pkg::cmd_t push_cmd;
	tpts_pkg::cmd_t pop_cmd;

	tpts_front #(.MAX_TASKS(MAX_TASKS)) u_front (
		.clk, .arst_n, .start, .busy, .opcode, .slot, .priority_req, .delay,
		.push, .push_cmd, .full
	);

	tpts_cmd_queue u_queue (
		.clk, .arst_n, .push, .push_cmd, .full, .pop, .empty, .pop_cmd
	);

	tpts_back #(.MAX_TASKS(MAX_TASKS)) u_back (
		.clk, .arst_n, .empty, .pop_cmd, .pop, .done, .next_task, .switch_request
	);

endmodule

>>> hdl/tpts_front.sv
module tpts_front #(
	parameter int MAX_TASKS = tpts_pkg::MAX_TASKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [2:0]      opcode,
	input  logic [3:0]      slot,
	input  logic [7:0]      priority_req,
	input  logic [31:0]     delay,
	output logic            push,
	output tpts_pkg::cmd_t  push_cmd,
	input  logic            full
);

	logic           vld_s1;
	tpts_pkg::cmd_t cmd_s1;
	tpts_pkg::cmd_t dec;
	logic           slot_ok;
	logic           accept;
	logic           load;

	assign slot_ok = 32'(slot) < MAX_TASKS;
	assign push    = vld_s1 && !full;
	assign busy    = vld_s1 && full;
	assign accept  = start && !busy;
	assign load    = !vld_s1 || push;
	assign push_cmd = cmd_s1;

	// Classify the beat; bad opcodes and out-of-range slots on create, wake and start become no-ops.
	always_comb begin
		dec.slot  = slot;
		dec.pri   = priority_req;
		dec.delay = delay;
		unique case (opcode)
			tpts_pkg::OPC_TICK:   dec.op = tpts_pkg::OP_TICK;
			tpts_pkg::OPC_CREATE: dec.op = slot_ok ? tpts_pkg::OP_CREATE : tpts_pkg::OP_NOP;
			tpts_pkg::OPC_YIELD:  dec.op = tpts_pkg::OP_YIELD;
			tpts_pkg::OPC_SLEEP:  dec.op = tpts_pkg::OP_SLEEP;
			tpts_pkg::OPC_WAKE:   dec.op = slot_ok ? tpts_pkg::OP_WAKE : tpts_pkg::OP_NOP;
			tpts_pkg::OPC_START:  dec.op = slot_ok ? tpts_pkg::OP_START : tpts_pkg::OP_NOP;
			default:              dec.op = tpts_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (load && accept) begin
			cmd_s1 <= dec;
		end
	end

endmodule

>>> hdl/tpts_cmd_queue.sv
module tpts_cmd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tpts_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output tpts_pkg::cmd_t  pop_cmd
);

	localparam int AW = $clog2(tpts_pkg::QUEUE_DEPTH);

	tpts_pkg::cmd_t      mem [tpts_pkg::QUEUE_DEPTH];
	logic [AW-1:0]       wptr_q;
	logic [AW-1:0]       rptr_q;
	logic [AW:0]         count_q;

	assign full    = count_q == (AW+1)'(tpts_pkg::QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign pop_cmd = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wptr_q] <= push_cmd;
	end

endmodule

>>> hdl/tpts_back.sv
module tpts_back #(
	parameter int MAX_TASKS = tpts_pkg::MAX_TASKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  tpts_pkg::cmd_t  pop_cmd,
	output logic            pop,
	output logic            done,
	output logic [3:0]      next_task,
	output logic            switch_request
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

	tpts_pkg::state_t state_q, state_nx;
	tpts_pkg::cmd_t   cmd_q;

	logic [7:0]  pri_mem   [MAX_TASKS];
	logic [31:0] wake_mem  [MAX_TASKS];
	logic [4:0]  stamp_mem [MAX_TASKS];
	logic [MAX_TASKS-1:0] used_q;

	logic [4:0]  stamp_cnt_q;
	logic [31:0] tick_q;
	logic [3:0]  cur_q;
	logic [3:0]  chosen_q;
	logic        started_q;

	logic [IW-1:0] rd_idx_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [7:0]    rd_pri_s1;
	logic [31:0]   rd_wake_s1;
	logic [4:0]    rd_stamp_s1;
	logic          rd_used_s1;

	logic          found_q;
	logic [IW-1:0] best_q;
	logic [7:0]    bpri_q;
	logic [4:0]    bage_q;

	logic          done_q;
	logic [3:0]    next_q;
	logic          sw_q;

	logic [IW-1:0] sidx;
	logic [IW-1:0] cidx;
	logic [32:0]   sum;
	logic [31:0]   yield_tick;
	logic          sched;
	logic          eligible;
	logic [4:0]    age;
	logic          take;
	logic [3:0]    chosen_nx;
	logic          do_pop;
	logic          do_exec;
	logic          do_scan;
	logic          do_drain;

	assign sidx = IW'(cmd_q.slot);
	assign cidx = (32'(cur_q) < MAX_TASKS) ? IW'(cur_q) : '0;
	assign sum  = {1'b0, tick_q} + {1'b0, cmd_q.delay};
	// Saturate so a yield never wraps early or turns into a sleep.
	assign yield_tick = (sum[32] || sum[31:0] == tpts_pkg::SLEEP_TICK) ?
		tpts_pkg::MAX_DELAY_TICK : sum[31:0];

	always_comb begin
		case (cmd_q.op)
			tpts_pkg::OP_NOP:    sched = 1'b0;
			tpts_pkg::OP_CREATE: sched = started_q;
			default:             sched = 1'b1;
		endcase
	end

	assign eligible = rd_vld_s1 && rd_used_s1 && rd_wake_s1 != tpts_pkg::SLEEP_TICK &&
		rd_wake_s1 <= tick_q;
	assign age  = stamp_cnt_q - 5'd1 - rd_stamp_s1;
	assign take = eligible && (!found_q || rd_pri_s1 < bpri_q ||
		(rd_pri_s1 == bpri_q && age < bage_q));
	assign chosen_nx = take ? 4'(rd_idx_s1) : (found_q ? 4'(best_q) : chosen_q);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tpts_pkg::ST_IDLE:  if (!empty) state_nx = tpts_pkg::ST_EXEC;
			tpts_pkg::ST_EXEC:  state_nx = sched ? tpts_pkg::ST_SCAN : tpts_pkg::ST_IDLE;
			tpts_pkg::ST_SCAN:  if (rd_idx_q == LAST_IDX) state_nx = tpts_pkg::ST_DRAIN;
			tpts_pkg::ST_DRAIN: state_nx = tpts_pkg::ST_IDLE;
			default:            state_nx = tpts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		do_pop = 1'b0; do_exec = 1'b0; do_scan = 1'b0; do_drain = 1'b0;
		unique case (state_q)
			tpts_pkg::ST_IDLE:  do_pop = !empty;
			tpts_pkg::ST_EXEC:  do_exec = 1'b1;
			tpts_pkg::ST_SCAN:  do_scan = 1'b1;
			tpts_pkg::ST_DRAIN: do_drain = 1'b1;
			default:            do_pop = 1'b0;
		endcase
	end

	assign pop = do_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpts_pkg::ST_IDLE;
			used_q      <= '0;
			stamp_cnt_q <= '0;
			tick_q      <= '0;
			cur_q       <= '0;
			chosen_q    <= '0;
			started_q   <= 1'b0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
			next_q      <= '0;
			sw_q        <= 1'b0;
		end else begin
			state_q   <= state_nx;
			done_q    <= do_drain || (do_exec && !sched);
			sw_q      <= do_drain;
			rd_vld_s1 <= do_scan;
			if (take) found_q <= 1'b1;
			if (do_exec) begin
				found_q  <= 1'b0;
				rd_idx_q <= '0;
				case (cmd_q.op)
					tpts_pkg::OP_TICK: tick_q <= tick_q + 32'd1;
					tpts_pkg::OP_CREATE: begin
						used_q[sidx] <= 1'b1;
						stamp_cnt_q  <= stamp_cnt_q + 5'd1;
					end
					tpts_pkg::OP_START: begin
						cur_q     <= cmd_q.slot;
						chosen_q  <= cmd_q.slot;
						started_q <= 1'b1;
					end
					default: ;
				endcase
				if (!sched) begin
					next_q <= chosen_q;
				end
			end
			if (do_scan) rd_idx_q <= rd_idx_q + 1'b1;
			if (do_drain) begin
				chosen_q <= chosen_nx;
				cur_q    <= chosen_nx;
				next_q   <= chosen_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) cmd_q <= pop_cmd;
		if (take) begin
			best_q <= rd_idx_s1;
			bpri_q <= rd_pri_s1;
			bage_q <= age;
		end
		if (do_scan) rd_idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk) begin
		if (do_exec) begin
			case (cmd_q.op)
				tpts_pkg::OP_CREATE: begin
					pri_mem[sidx]   <= cmd_q.pri;
					wake_mem[sidx]  <= '0;
					stamp_mem[sidx] <= stamp_cnt_q;
				end
				tpts_pkg::OP_YIELD: wake_mem[cidx] <= yield_tick;
				tpts_pkg::OP_SLEEP: wake_mem[cidx] <= tpts_pkg::SLEEP_TICK;
				tpts_pkg::OP_WAKE:  wake_mem[sidx] <= '0;
				default: ;
			endcase
		end
		if (do_scan) begin
			rd_pri_s1   <= pri_mem[rd_idx_q];
			rd_wake_s1  <= wake_mem[rd_idx_q];
			rd_stamp_s1 <= stamp_mem[rd_idx_q];
			rd_used_s1  <= used_q[rd_idx_q];
		end
	end

	assign done           = done_q;
	assign next_task      = next_q;
	assign switch_request = sw_q;

endmodule

>>> hdl/tpts_checker.sv
`include "tick_priority_task_scheduler_assert.svh"

module tpts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [3:0]  next_task,
	input logic        switch_request
);

	// A result is never directly followed by another.
	`TPTS_ASSERT_NEXT(a_done_spaced, done, !done)
	// Switch request only rides on a result beat.
	`TPTS_ASSERT_NOW(a_switch_with_done, switch_request, done)
	// Back pressure only builds after a beat was offered.
	`TPTS_ASSERT_NOW(a_busy_after_start, $rose(busy), $past(start))
	// A result without a switch leaves the previous choice.
	`TPTS_ASSERT_NOW(a_noswitch_keeps_task, done && !switch_request, next_task == $past(next_task))

endmodule

bind tick_priority_task_scheduler tpts_checker u_chk (.*);

>>> verif/tb_tick_priority_task_scheduler.sv
module tb_tick_priority_task_scheduler;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  opcode;
	logic [3:0]  slot;
	logic [7:0]  priority_req;
	logic [31:0] delay;
	logic        done;
	logic [3:0]  next_task;
	logic        switch_request;

	tick_priority_task_scheduler DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .slot(slot), .priority_req(priority_req), .delay(delay),
		.done(done), .next_task(next_task), .switch_request(switch_request)
	);

	localparam int NTASK = tpts_pkg::MAX_TASKS_DEF;
	localparam logic [2:0] OPC_BAD6 = 3'd6;
	localparam logic [2:0] OPC_BAD7 = 3'd7;

	typedef struct {
		logic [3:0] task_id;
		logic       sw;
	} sched_res_t;

	typedef struct {
		logic [2:0]  op;
		logic [3:0]  sl;
		logic [7:0]  pr;
		logic [31:0] dl;
		logic        has_exp;
		logic [3:0]  exp_task;
		logic        exp_sw;
	} dir_row_t;

	// scheduler mirror
	logic [7:0]  m_pri [NTASK];
	logic [31:0] m_wake [NTASK];
	logic        m_used [NTASK];
	logic [4:0]  m_stamp [NTASK];
	logic [4:0]  m_stamp_cnt;
	logic [31:0] m_ticks;
	logic [3:0]  m_cur;
	logic [3:0]  m_chosen;
	logic        m_started;

	sched_res_t pending_sched[$];
	int errors;
	int n_beats;
	int n_results;
	int n_switches;
	int stretch_lo, stretch_hi;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("tb_tick_priority_task_scheduler: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_results);
		errors++;
	endtask

	function automatic void mirror_reset();
		for (int i = 0; i < NTASK; i++) begin
			m_used[i] = 0;
			m_pri[i] = '0;
			m_wake[i] = '0;
			m_stamp[i] = '0;
		end
		m_stamp_cnt = '0;
		m_ticks = '0;
		m_cur = '0;
		m_chosen = '0;
		m_started = 0;
	endfunction

	function automatic void pick_task();
		logic found;
		logic [3:0] best;
		logic [7:0] best_pri;
		logic [4:0] best_age, age;
		found = 0;
		best = '0;
		best_pri = '0;
		best_age = '0;
		for (int i = 0; i < NTASK; i++) begin
			if (m_used[i] && m_wake[i] != tpts_pkg::SLEEP_TICK &&
				m_wake[i] <= m_ticks) begin
				age = m_stamp_cnt - 5'd1 - m_stamp[i];
				if (!found || m_pri[i] < best_pri ||
					(m_pri[i] == best_pri && age < best_age)) begin
					found = 1;
					best = i[3:0];
					best_pri = m_pri[i];
					best_age = age;
				end
			end
		end
		if (found)
			m_chosen = best;
		m_cur = m_chosen;
	endfunction

	function automatic sched_res_t predict_sched(input logic [2:0] op, input logic [3:0] sl,
		input logic [7:0] pr, input logic [31:0] dl);
		sched_res_t r;
		logic       run;
		logic [32:0] sum;
		run = 0;
		case (op)
			tpts_pkg::OPC_TICK: begin
				m_ticks = m_ticks + 32'd1;
				run = 1;
			end
			tpts_pkg::OPC_CREATE: begin
				m_pri[sl] = pr;
				m_wake[sl] = '0;
				m_stamp[sl] = m_stamp_cnt;
				m_used[sl] = 1;
				m_stamp_cnt = m_stamp_cnt + 5'd1;
				run = m_started;
			end
			tpts_pkg::OPC_YIELD: begin
				sum = {1'b0, m_ticks} + {1'b0, dl};
				// saturate so a yield never wraps or turns into a sleep
				m_wake[m_cur] = (sum > {1'b0, tpts_pkg::MAX_DELAY_TICK}) ?
					tpts_pkg::MAX_DELAY_TICK : sum[31:0];
				run = 1;
			end
			tpts_pkg::OPC_SLEEP: begin
				m_wake[m_cur] = tpts_pkg::SLEEP_TICK;
				run = 1;
			end
			tpts_pkg::OPC_WAKE: begin
				m_wake[sl] = '0;
				run = 1;
			end
			tpts_pkg::OPC_START: begin
				m_cur = sl;
				m_chosen = sl;
				m_started = 1;
				run = 1;
			end
			default: ;
		endcase
		if (run)
			pick_task();
		r.task_id = m_chosen;
		r.sw = run;
		return r;
	endfunction

	always @(posedge clk) begin
		sched_res_t e;
		if (arst_n && done) begin
			n_results++;
			if (pending_sched.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				e = pending_sched.pop_front();
				if (next_task !== e.task_id)
					report_mismatch("next_task", int'(next_task), int'(e.task_id));
				if (switch_request !== e.sw)
					report_mismatch("switch_request", int'(switch_request), int'(e.sw));
				if (e.sw)
					n_switches++;
			end
		end
	end

	// hold the beat until the block takes it
	task automatic send_beat(input logic [2:0] op, input logic [3:0] sl, input logic [7:0] pr,
		input logic [31:0] dl, input logic chk, input logic [3:0] want_task, input logic want_sw);
		sched_res_t r;
		while (n_beats >= stretch_lo && n_beats < stretch_hi ? 0 : ($urandom_range(99) < 24))
		begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		opcode <= op;
		slot <= sl;
		priority_req <= pr;
		delay <= dl;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = predict_sched(op, sl, pr, dl);
		if (chk && (r.task_id !== want_task || r.sw !== want_sw))
			report_mismatch("directed row", int'(r.task_id), int'(want_task));
		pending_sched.push_back(r);
		n_beats++;
	endtask

	function automatic logic [31:0] rand_delay();
		case ($urandom_range(5))
			0: return '0;
			1: return 32'hFFFF_FFFE;
			2: return $urandom;
			default: return $urandom_range(6);
		endcase
	endfunction

	dir_row_t dir_rows[$];

	function automatic void add_row(input logic [2:0] op, input logic [3:0] sl,
		input logic [7:0] pr, input logic [31:0] dl, input logic he,
		input logic [3:0] et, input logic es);
		dir_row_t d;
		d.op = op; d.sl = sl; d.pr = pr; d.dl = dl;
		d.has_exp = he; d.exp_task = et; d.exp_sw = es;
		dir_rows.push_back(d);
	endfunction

	initial begin
		int wait_cnt;
		logic [2:0] op;
		errors = 0;
		n_beats = 0;
		n_results = 0;
		n_switches = 0;
		start = 0;
		opcode = '0;
		slot = '0;
		priority_req = '0;
		delay = '0;
		arst_n = 0;
		mirror_reset();
		stretch_lo = 600 + $urandom_range(300);
		stretch_hi = stretch_lo + 300;

		// after reset, before start, extremes, bad opcodes
		add_row(tpts_pkg::OPC_TICK, 4'd0, 8'd0, 32'd0, 1, 4'd0, 1);
		add_row(OPC_BAD6, 4'd3, 8'd0, 32'd0, 1, 4'd0, 0);
		add_row(OPC_BAD7, 4'd15, 8'hFF, 32'hFFFF_FFFF, 1, 4'd0, 0);
		add_row(tpts_pkg::OPC_CREATE, 4'd15, 8'hFF, 32'd0, 1, 4'd0, 0);
		add_row(tpts_pkg::OPC_CREATE, 4'd0, 8'd0, 32'd0, 1, 4'd0, 0);
		add_row(tpts_pkg::OPC_CREATE, 4'd5, 8'd0, 32'd0, 1, 4'd0, 0);
		add_row(tpts_pkg::OPC_START, 4'd15, 8'd0, 32'd0, 1, 4'd5, 1);
		add_row(tpts_pkg::OPC_YIELD, 4'd0, 8'd0, 32'd3, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_YIELD, 4'd0, 8'd0, 32'hFFFF_FFFE, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_SLEEP, 4'd0, 8'd0, 32'd0, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_TICK, 4'd0, 8'd0, 32'd0, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_WAKE, 4'd5, 8'd0, 32'd0, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_WAKE, 4'd9, 8'd0, 32'd0, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_CREATE, 4'd7, 8'd0, 32'd0, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_CREATE, 4'd5, 8'd0, 32'd0, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_SLEEP, 4'd0, 8'd0, 32'd0, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_SLEEP, 4'd0, 8'd0, 32'd0, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_SLEEP, 4'd0, 8'd0, 32'd0, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_YIELD, 4'd0, 8'd0, 32'd1, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_TICK, 4'd0, 8'd0, 32'd0, 0, 4'd0, 0);
		add_row(tpts_pkg::OPC_START, 4'd10, 8'd0, 32'd0, 0, 4'd0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].op, dir_rows[i].sl, dir_rows[i].pr, dir_rows[i].dl,
				dir_rows[i].has_exp, dir_rows[i].exp_task, dir_rows[i].exp_sw);

		for (int n = 0; n < 2000; n++) begin
			case ($urandom_range(99)) inside
				[0:29]:  op = tpts_pkg::OPC_TICK;
				[30:49]: op = tpts_pkg::OPC_CREATE;
				[50:64]: op = tpts_pkg::OPC_YIELD;
				[65:74]: op = tpts_pkg::OPC_SLEEP;
				[75:89]: op = tpts_pkg::OPC_WAKE;
				[90:95]: op = tpts_pkg::OPC_START;
				default: op = ($urandom_range(1) != 0) ? OPC_BAD7 : OPC_BAD6;
			endcase
			// few priority levels so recency ties show up often
			send_beat(op, 4'($urandom_range(15)),
				($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
				rand_delay(), 0, 4'd0, 0);
		end
		start <= 0;

		wait_cnt = 0;
		while (pending_sched.size() != 0 && wait_cnt < 2000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (60) @(posedge clk);
		$display("covered %0d operation beats, %0d results, %0d with a switch request",
			n_beats, n_results, n_switches);
		$display("ticks reached %0d, stamp counter at %0d", m_ticks, m_stamp_cnt);
		if (errors == 0 && pending_sched.size() == 0)
			$display("tb_tick_priority_task_scheduler: PASS");
		else
			$display("tb_tick_priority_task_scheduler: FAIL");
		$finish;
	end
endmodule
